// ===== src/sliding_window_maximum_core_macros.svh =====
// Assertion macros for the sliding window maximum core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, masked while reset is asserted
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked property, also evaluated during reset
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum core.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps

package swm_pkg;

    // Configuration register layout
    localparam int          WIN_W       = 7;
    localparam logic [6:0]  WIN_RESET   = 7'd3;
    localparam int          APB_DW      = 32;
    localparam int          APB_AW      = 3;
    // Word index of the window size register
    localparam logic        CFG_WINDOW  = 1'b0;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PURGE = 2'b10
    } t_state;

    // Broadcast control for the cell row
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic start;    // request opens a new stream
        logic shift;    // front entry expires: row moves one place toward the head
        logic purge;    // plain one-place shift, drops an expired front entry
    } t_cell_ctrl;

endpackage

// ===== src/swm_if.sv =====
// Valid/ready stream interfaces for samples in and window maxima out.
// No dependencies.
`timescale 1ns / 1ps

interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_of_stream;
    logic                           last_of_stream;

    modport source (output valid, sample, start_of_stream, last_of_stream, input ready);
    modport sink   (input valid, sample, start_of_stream, last_of_stream, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           last_result;

    modport source (output valid, window_max, last_result, input ready);
    modport sink   (input valid, window_max, last_result, output ready);
endinterface

// ===== src/swm_cell.sv =====
// One entry of the monotonic queue: value, age and valid bit.
// Depends on swm_pkg (t_cell_ctrl); neighbors are wired by the top level.
`timescale 1ns / 1ps

module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_WIDTH    = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swm_pkg::t_cell_ctrl            i_ctrl,
    input  logic                           i_head,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_prv_keep,
    input  logic                           i_nxt_keep,
    input  logic signed [SAMPLE_WIDTH-1:0] i_nxt_value,
    input  logic        [AGE_WIDTH-1:0]    i_nxt_age,
    input  logic                           i_nxt_valid,
    output logic                           o_keep,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [AGE_WIDTH-1:0]    o_age,
    output logic                           o_valid
);

    logic signed [SAMPLE_WIDTH-1:0] r_value, n_value;
    logic        [AGE_WIDTH-1:0]    r_age, n_age;
    logic                           r_valid, n_valid;
    logic                           w_keep;
    logic                           w_src_keep;
    logic                           w_src_prev;
    logic signed [SAMPLE_WIDTH-1:0] w_src_value;
    logic        [AGE_WIDTH-1:0]    w_src_age;

    // Entry survives the new sample unless it is smaller or the stream restarts
    assign w_keep = r_valid & ~i_ctrl.start & (r_value >= i_sample);

    // Source of the new content: this cell, or the neighbor behind it on a shift
    assign w_src_keep  = i_ctrl.shift ? i_nxt_keep  : w_keep;
    assign w_src_value = i_ctrl.shift ? i_nxt_value : r_value;
    assign w_src_age   = i_ctrl.shift ? i_nxt_age   : r_age;
    // Sample lands right after the last survivor, or at the head
    assign w_src_prev  = i_head | (i_ctrl.shift ? w_keep : i_prv_keep);

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        if (i_ctrl.purge) begin
            n_value = i_nxt_value;
            n_age   = i_nxt_age;
            n_valid = i_nxt_valid;
        end else if (i_ctrl.accept) begin
            if (w_src_keep) begin
                n_value = w_src_value;
                n_age   = w_src_age + AGE_WIDTH'(1);
                n_valid = 1'b1;
            end else if (w_src_prev) begin
                n_value = i_sample;
                n_age   = '0;
                n_valid = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Valid bit is control state; value and age are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_keep  = w_keep;
    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;

endmodule

// ===== src/sliding_window_maximum_core.sv =====
// Sliding window maximum core: running maximum of the last window_size samples of a stream.
// A row of WINDOW_MAX cells holds a monotonic queue packed toward cell 0, oldest
// first; every cell compares its entry with the incoming sample in parallel. The
// queue settles in the cell registers; its front, cell 0, is the window maximum and
// is loaded into the output register once that is free. The row moves at most
// one place per cycle, so when window_size has been lowered since the last sample,
// expired entries beyond the first are purged after the next sample, with input
// held; otherwise the block sustains one sample per clock while output is free.
// A sample with start_of_stream set restarts the queue and the sample count;
// the first window_size - 1 samples of a stream give no result. Register 0 at
// byte address 0 is window_size (values 0 and above WINDOW_MAX are clamped).
// Depends on swm_pkg, swm_if, swm_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "sliding_window_maximum_core_macros.svh"

module sliding_window_maximum_core #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swm_in_if.sink                            i_in,
    swm_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::APB_AW-1:0]        paddr,
    input  logic [swm_pkg::APB_DW-1:0]        pwdata,
    output logic [swm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (AGE_W > swm_pkg::WIN_W) ? AGE_W : swm_pkg::WIN_W;

    // Cell row taps; the extra slot past the tail reads as empty
    logic signed [SAMPLE_WIDTH-1:0] c_value [WINDOW_MAX+1];
    logic        [AGE_W-1:0]        c_age   [WINDOW_MAX+1];
    logic                           c_valid [WINDOW_MAX+1];
    logic                           c_keep  [WINDOW_MAX+1];
    logic                           w_prv_keep [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]   w_valid_vec;

    logic [swm_pkg::WIN_W-1:0]      r_window_size;
    swm_pkg::t_state                r_state, n_state;
    logic [AGE_W-1:0]               r_seen, n_seen;
    logic                           r_emit, n_emit;
    logic                           r_last;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_value;
    logic                           r_out_last;

    logic [CMP_W-1:0]               w_ws_ext;
    logic [AGE_W-1:0]               w_k;
    logic [AGE_W:0]                 w_age0_p1;
    logic [AGE_W:0]                 w_age1_p1;
    logic [AGE_W-1:0]               w_seen_base;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_load;
    logic                           w_shift;
    logic                           w_more_acc;
    logic                           w_more_pur;
    swm_pkg::t_cell_ctrl            w_ctrl;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WIN_RESET;
        end else if (psel && penable && pwrite
                     && (paddr[swm_pkg::APB_AW-1] == swm_pkg::CFG_WINDOW)) begin
            r_window_size <= pwdata[swm_pkg::WIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[swm_pkg::APB_AW-1] == swm_pkg::CFG_WINDOW)
                    ? swm_pkg::APB_DW'(r_window_size) : '0;

    // Effective window: zero acts as one, large values clamp to the row length
    assign w_ws_ext = CMP_W'(r_window_size);
    always_comb begin
        if (w_ws_ext == '0) begin
            w_k = AGE_W'(1);
        end else if (w_ws_ext > CMP_W'(WINDOW_MAX)) begin
            w_k = AGE_W'(WINDOW_MAX);
        end else begin
            w_k = AGE_W'(w_ws_ext);
        end
    end

    // Handshakes
    assign w_out_free = ~r_out_valid | o_out.ready;
    assign i_in.ready = (r_state == swm_pkg::ST_IDLE) & (~r_emit | w_out_free);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_load     = (r_state == swm_pkg::ST_IDLE) & r_emit & w_out_free;

    // Expiry of the front entries
    assign w_age0_p1  = {1'b0, c_age[0]} + (AGE_W+1)'(1);
    assign w_age1_p1  = {1'b0, c_age[1]} + (AGE_W+1)'(1);
    assign w_shift    = w_accept & c_valid[0] & ~i_in.start_of_stream
                        & (w_age0_p1 >= {1'b0, w_k});
    assign w_more_acc = w_shift & c_keep[1] & (w_age1_p1 >= {1'b0, w_k});
    assign w_more_pur = c_valid[1] & (c_age[1] >= w_k);

    always_comb begin
        w_ctrl.accept = w_accept;
        w_ctrl.start  = i_in.start_of_stream;
        w_ctrl.shift  = w_shift;
        w_ctrl.purge  = (r_state == swm_pkg::ST_PURGE);
    end

    // Cell row
    assign c_value[WINDOW_MAX] = '0;
    assign c_age[WINDOW_MAX]   = '0;
    assign c_valid[WINDOW_MAX] = 1'b0;
    assign c_keep[WINDOW_MAX]  = 1'b0;

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_prv_keep[gi] = 1'b0;
        end else begin : g_body
            assign w_prv_keep[gi] = c_keep[gi-1];
        end

        assign w_valid_vec[gi] = c_valid[gi];

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AGE_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_head      (1'(gi == 0)),
            .i_sample    (i_in.sample),
            .i_prv_keep  (w_prv_keep[gi]),
            .i_nxt_keep  (c_keep[gi+1]),
            .i_nxt_value (c_value[gi+1]),
            .i_nxt_age   (c_age[gi+1]),
            .i_nxt_valid (c_valid[gi+1]),
            .o_keep      (c_keep[gi]),
            .o_value     (c_value[gi]),
            .o_age       (c_age[gi]),
            .o_valid     (c_valid[gi])
        );
    end

    // Sequencer: purge extra expired entries one place per cycle
    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (w_more_acc) begin
                    n_state = swm_pkg::ST_PURGE;
                end
            end
            swm_pkg::ST_PURGE: begin
                if (!w_more_pur) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sample count per stream, saturating at the row length
    assign w_seen_base = i_in.start_of_stream ? '0 : r_seen;
    always_comb begin
        n_seen = r_seen;
        n_emit = w_load ? 1'b0 : r_emit;
        if (w_accept) begin
            n_seen = (w_seen_base < AGE_W'(WINDOW_MAX)) ? w_seen_base + AGE_W'(1)
                                                         : w_seen_base;
            n_emit = (n_seen >= w_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_IDLE;
            r_seen      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_emit  <= n_emit;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register: the front of the settled queue
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_in.last_of_stream;
        end
        if (w_load) begin
            r_out_value <= c_value[0];
            r_out_last  <= r_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.window_max  = r_out_value;
    assign o_out.last_result = r_out_last;

    // Checks
    `SWM_ASSERT(a_queue_packed, i_clk, i_rst_n,
        $onehot((WINDOW_MAX+1)'(w_valid_vec) + (WINDOW_MAX+1)'(1)),
        "queue entries not packed toward the head")
    `SWM_ASSERT(a_purge_has_front, i_clk, i_rst_n,
        (r_state == swm_pkg::ST_PURGE) |-> c_valid[0],
        "purge with an empty queue")
    `SWM_ASSERT(a_start_single, i_clk, i_rst_n,
        (w_accept && i_in.start_of_stream) |=> (w_valid_vec == WINDOW_MAX'(1)),
        "stream start left more than one entry")
    `SWM_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> ((r_state == swm_pkg::ST_IDLE) && !o_out.valid),
        "reset did not return to idle")

endmodule
